>>> rtl/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is held.
`define PUG_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that also holds during reset.
`define PUG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/pug_pkg.sv
// ----------------------------------------------------------------------------
// Polar unwarp package
// Shared types and constants of the polar unwarp coordinate generator.
// ----------------------------------------------------------------------------
package pug_pkg;

    localparam int MAX_RADIUS_DEF       = 2048;
    localparam int MAX_ANGLES_DEF       = 8192;
    localparam int SINE_TABLE_DEPTH_DEF = 1024;

    localparam int ANGLE_W  = 13;
    localparam int RADIUS_W = 11;
    localparam int COORD_W  = 12;
    localparam int COUNT_W  = 14;
    localparam int PHASE_W  = 16;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    localparam logic [1:0] REG_CENTER_X    = 2'd0;
    localparam logic [1:0] REG_CENTER_Y    = 2'd1;
    localparam logic [1:0] REG_ANGLE_COUNT = 2'd2;

    typedef struct packed {
        logic [ANGLE_W-1:0]  angle_index;
        logic [RADIUS_W-1:0] radius;
    } t_pug_in;

    typedef struct packed {
        logic [COORD_W-1:0] source_x;
        logic [COORD_W-1:0] source_y;
        logic               angle_valid;
    } t_pug_out;

    typedef struct packed {
        logic [PHASE_W-1:0]  phase;
        logic [RADIUS_W-1:0] radius;
        logic                angle_valid;
    } t_pug_item;

    typedef struct packed {
        logic full;
        logic head_valid;
    } t_pug_qstat;

endpackage

>>> rtl/pug_front.sv
// ----------------------------------------------------------------------------
// Polar unwarp front end
// Clamps the radius, flags the angle and turns it into a 16-bit phase
// through a pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module pug_front #(
    parameter int MAX_RADIUS = pug_pkg::MAX_RADIUS_DEF,
    parameter int MAX_ANGLES = pug_pkg::MAX_ANGLES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  pug_pkg::t_pug_in              i_data,
    input  logic [pug_pkg::COUNT_W-1:0]   i_angle_count,
    input  pug_pkg::t_pug_qstat           i_qstat,
    output logic                          o_push,
    output pug_pkg::t_pug_item            o_item
);
    import pug_pkg::*;

    localparam int DW = ANGLE_W + PHASE_W;
    localparam logic [COUNT_W:0]    MAXA = (COUNT_W+1)'(MAX_ANGLES);
    localparam logic [RADIUS_W+1:0] MAXR = (RADIUS_W+2)'(MAX_RADIUS);
    localparam logic [RADIUS_W+1:0] RLIM = (RADIUS_W+2)'(MAX_RADIUS - 1);

    logic                 fe;
    logic [COUNT_W-1:0]   cnt;
    logic [RADIUS_W-1:0]  rad_c;

    logic                 r_vld  [0:DW];
    logic [ANGLE_W-1:0]   r_a    [0:DW];
    logic [RADIUS_W-1:0]  r_rad  [0:DW];
    logic                 r_flag [0:DW];
    logic [COUNT_W-1:0]   r_rem  [0:DW];
    logic [PHASE_W-1:0]   r_q    [0:DW];

    assign fe      = !i_qstat.full;
    assign o_stall = !fe;
    assign cnt     = ({1'b0, i_angle_count} > MAXA) ? MAXA[COUNT_W-1:0] : i_angle_count;
    assign rad_c   = ({2'b00, i_data.radius} >= MAXR) ? RLIM[RADIUS_W-1:0] : i_data.radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (fe) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fe) begin
            r_a[0]    <= i_data.angle_index;
            r_rad[0]  <= rad_c;
            r_flag[0] <= ({1'b0, i_data.angle_index} < cnt);
            r_rem[0]  <= '0;
            r_q[0]    <= '0;
        end
    end

    for (genvar s = 1; s <= DW; s++) begin : g_stage
        localparam int J = DW - s;
        logic               dbit;
        logic [COUNT_W:0]   trial;
        logic               ge;
        logic [COUNT_W:0]   diff;

        if (J >= PHASE_W) begin : g_abit
            assign dbit = r_a[s-1][J-PHASE_W];
        end else begin : g_zbit
            assign dbit = 1'b0;
        end

        assign trial = {r_rem[s-1], dbit};
        assign ge    = trial >= {1'b0, cnt};
        assign diff  = ge ? (trial - {1'b0, cnt}) : trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (fe) begin
                r_vld[s] <= r_vld[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (fe) begin
                r_a[s]    <= r_a[s-1];
                r_rad[s]  <= r_rad[s-1];
                r_flag[s] <= r_flag[s-1];
                r_rem[s]  <= diff[COUNT_W-1:0];
                r_q[s]    <= {r_q[s-1][PHASE_W-2:0], ge};
            end
        end
    end

    assign o_push             = fe && r_vld[DW];
    assign o_item.phase       = (cnt == '0) ? '0 : r_q[DW];
    assign o_item.radius      = r_rad[DW];
    assign o_item.angle_valid = r_flag[DW];

endmodule

>>> rtl/pug_queue.sv
// ----------------------------------------------------------------------------
// Polar unwarp queue
// Four-entry queue that parts the front end from the back end.
// ----------------------------------------------------------------------------
module pug_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  pug_pkg::t_pug_item    i_item,
    input  logic                  i_pop,
    output pug_pkg::t_pug_qstat   o_qstat,
    output pug_pkg::t_pug_item    o_head
);
    import pug_pkg::*;

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    t_pug_item        r_mem [0:DEPTH-1];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [PW:0]      r_cnt;
    logic             do_pop;

    assign do_pop             = i_pop && (r_cnt != '0);
    assign o_qstat.full       = (r_cnt == (PW+1)'(DEPTH));
    assign o_qstat.head_valid = (r_cnt != '0);
    assign o_head             = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> rtl/pug_back.sv
// ----------------------------------------------------------------------------
// Polar unwarp back end
// Looks up sine and cosine in a quarter-wave table, scales them by the
// radius, adds the centre and saturates; the last stage is the output.
// ----------------------------------------------------------------------------
module pug_back #(
    parameter int SINE_TABLE_DEPTH = pug_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pug_pkg::t_pug_qstat           i_qstat,
    input  pug_pkg::t_pug_item            i_head,
    output logic                          o_pop,
    input  logic [pug_pkg::COORD_W-1:0]   i_center_x,
    input  logic [pug_pkg::COORD_W-1:0]   i_center_y,
    output logic                          o_valid,
    input  logic                          i_stall,
    output pug_pkg::t_pug_out             o_data
);
    import pug_pkg::*;

    localparam int LD  = $clog2(SINE_TABLE_DEPTH);
    localparam int SH  = PHASE_W - LD - 2;
    localparam int TW  = 15;
    localparam int PW  = RADIUS_W + TW;
    localparam int SW  = COORD_W + TW + 2;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned SERIES_DIV [0:7] = '{6, 20, 42, 72, 110, 156, 210, 272};

    typedef logic [TW-1:0] t_tab [0:SINE_TABLE_DEPTH];

    function automatic t_tab build_tab();
        t_tab             tab;
        longint unsigned  x;
        longint unsigned  x2;
        longint unsigned  term;
        longint           sum;
        longint unsigned  v;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            x    = (longint'(k) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int n = 0; n < 8; n++) begin
                term = ((term * x2) >> 30) / SERIES_DIV[n];
                if (n % 2 == 1) begin
                    sum = sum + longint'(term);
                end else begin
                    sum = sum - longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            if (sum > longint'(Q30_ONE)) begin
                sum = longint'(Q30_ONE);
            end
            v      = (longint'(sum) * 64'd32767 + (Q30_ONE >> 1)) >> 30;
            tab[k] = v[TW-1:0];
        end
        return tab;
    endfunction

    localparam t_tab SINE_TAB = build_tab();

    function automatic logic [LD+1:0] lookup(input logic [PHASE_W-1:0] ph);
        logic [LD+1:0] idx;
        logic [LD:0]   k;
        idx = (LD+2)'(ph >> SH);
        k   = {1'b0, idx[LD-1:0]};
        if (idx[LD]) begin
            k = (LD+1)'(SINE_TABLE_DEPTH) - k;
        end
        return {idx[LD+1], k};
    endfunction

    logic                 en;
    logic [PHASE_W-1:0]   phase_c;
    logic [LD+1:0]        lk_s;
    logic [LD+1:0]        lk_c;

    logic                 r_v1, r_v2, r_v3, r_v4;
    logic [LD:0]          r_as, r_ac;
    logic                 r_n1s, r_n1c, r_n2s, r_n2c, r_n3s, r_n3c;
    logic [RADIUS_W-1:0]  r_r1, r_r2;
    logic                 r_f1, r_f2, r_f3;
    logic [TW-1:0]        r_ts, r_tc;
    logic [PW-1:0]        r_ps, r_pc;
    t_pug_out             r_out;

    logic signed [SW-1:0] tot_x, tot_y;

    assign en      = !r_v4 || !i_stall;
    assign o_pop   = en && i_qstat.head_valid;
    assign phase_c = i_head.phase + PHASE_W'(16384);
    assign lk_s    = lookup(i_head.phase);
    assign lk_c    = lookup(phase_c);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_qstat.head_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    function automatic logic [COORD_W-1:0] sat(input logic signed [SW-1:0] t);
        logic [SW-TW-2:0] v;
        v = t[SW-2:TW];
        if (t[SW-1]) begin
            return '0;
        end else if (v > (SW-TW-1)'(4095)) begin
            return '1;
        end
        return v[COORD_W-1:0];
    endfunction

    function automatic logic signed [SW-1:0] total(input logic [COORD_W-1:0] c,
                                                   input logic [PW-1:0] p,
                                                   input logic neg);
        logic signed [SW-1:0] base;
        logic signed [SW-1:0] prod;
        base = $signed({2'b00, c, {TW{1'b0}}});
        prod = $signed({{(SW-PW){1'b0}}, p});
        return neg ? (base - prod) : (base + prod);
    endfunction

    assign tot_x = total(i_center_x, r_ps, r_n3s);
    assign tot_y = total(i_center_y, r_pc, r_n3c);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_as  <= lk_s[LD:0];
            r_ac  <= lk_c[LD:0];
            r_n1s <= lk_s[LD+1];
            r_n1c <= lk_c[LD+1];
            r_r1  <= i_head.radius;
            r_f1  <= i_head.angle_valid;

            r_ts  <= SINE_TAB[r_as];
            r_tc  <= SINE_TAB[r_ac];
            r_n2s <= r_n1s;
            r_n2c <= r_n1c;
            r_r2  <= r_r1;
            r_f2  <= r_f1;

            r_ps  <= r_r2 * r_ts;
            r_pc  <= r_r2 * r_tc;
            r_n3s <= r_n2s;
            r_n3c <= r_n2c;
            r_f3  <= r_f2;

            r_out.source_x    <= sat(tot_x);
            r_out.source_y    <= sat(tot_y);
            r_out.angle_valid <= r_f3;
        end
    end

    assign o_valid = r_v4;
    assign o_data  = r_out;

endmodule

>>> rtl/polar_unwarp_coordinate_generator.sv
// ----------------------------------------------------------------------------
// Polar unwarp coordinate generator
// Maps a panorama pixel (angle column, radius row) to its source pixel in a
// circular fisheye image.
//
// Input beats arrive on i_in_valid / o_in_stall with i_in_data; result beats
// leave on o_out_valid / i_out_stall with o_out_data. Each input beat gives
// exactly one result beat, in order.
// One beat is taken every cycle while o_in_stall is low. The phase comes
// from a 30-stage divider pipeline that yields one quotient bit per stage,
// a four-entry queue follows, and the back end takes four stages for table
// read, multiply and saturation.
// The centre and angle count registers sit on an APB port; the user must
// write them only while the block is empty, the block does not enforce it.
// After reset the pipelines and queue are empty and the registers hold
// centre zero and an angle count of 2048. When the receiver stalls the back
// end holds its output beat, the queue fills and then the front end raises
// o_in_stall.
// ----------------------------------------------------------------------------
module polar_unwarp_coordinate_generator #(
    parameter int MAX_RADIUS       = pug_pkg::MAX_RADIUS_DEF,
    parameter int MAX_ANGLES       = pug_pkg::MAX_ANGLES_DEF,
    parameter int SINE_TABLE_DEPTH = pug_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  pug_pkg::t_pug_in              i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output pug_pkg::t_pug_out             o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pug_pkg::APB_AW-1:0]    paddr,
    input  logic [pug_pkg::APB_DW-1:0]    pwdata,
    output logic [pug_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import pug_pkg::*;

    logic [COORD_W-1:0] r_center_x;
    logic [COORD_W-1:0] r_center_y;
    logic [COUNT_W-1:0] r_angle_count;
    logic               wr;

    t_pug_qstat         qstat;
    t_pug_item          push_item;
    t_pug_item          head;
    logic               push;
    logic               pop;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x    <= '0;
            r_center_y    <= '0;
            r_angle_count <= COUNT_W'(2048);
        end else if (wr) begin
            case (paddr[3:2])
                REG_CENTER_X:    r_center_x    <= pwdata[COORD_W-1:0];
                REG_CENTER_Y:    r_center_y    <= pwdata[COORD_W-1:0];
                REG_ANGLE_COUNT: r_angle_count <= pwdata[COUNT_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_CENTER_X:    prdata = {{(APB_DW-COORD_W){1'b0}}, r_center_x};
            REG_CENTER_Y:    prdata = {{(APB_DW-COORD_W){1'b0}}, r_center_y};
            REG_ANGLE_COUNT: prdata = {{(APB_DW-COUNT_W){1'b0}}, r_angle_count};
            default:         prdata = '0;
        endcase
    end

    pug_front #(
        .MAX_RADIUS (MAX_RADIUS),
        .MAX_ANGLES (MAX_ANGLES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_stall       (o_in_stall),
        .i_data        (i_in_data),
        .i_angle_count (r_angle_count),
        .i_qstat       (qstat),
        .o_push        (push),
        .o_item        (push_item)
    );

    pug_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_qstat (qstat),
        .o_head  (head)
    );

    pug_back #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_qstat    (qstat),
        .i_head     (head),
        .o_pop      (pop),
        .i_center_x (r_center_x),
        .i_center_y (r_center_y),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_data     (o_out_data)
    );

endmodule

>>> rtl/pug_checker.sv
// ----------------------------------------------------------------------------
// Polar unwarp port checker
// Watches the top-level ports for reset, output hold and register read-back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pug_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  pug_pkg::t_pug_out             i_out_data,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [pug_pkg::APB_AW-1:0]    i_paddr,
    input  logic [pug_pkg::APB_DW-1:0]    i_pwdata,
    input  logic [pug_pkg::APB_DW-1:0]    i_prdata,
    input  logic                          i_pready
);
    import pug_pkg::*;

    `PUG_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid, "beat after reset")

    `PUG_ASSERT(a_hold, i_clk, i_rst_n,
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_data), "stalled beat moved")

    `PUG_ASSERT_ALWAYS(a_ready, i_clk, i_psel |-> i_pready, "pready low")

    `PUG_ASSERT(a_readback, i_clk, i_rst_n,
        i_psel && i_penable && i_pwrite && (i_paddr[3:2] == REG_CENTER_X)
            |=> (i_paddr != $past(i_paddr))
                || (i_prdata[COORD_W-1:0] == $past(i_pwdata[COORD_W-1:0])),
        "read-back wrong")

endmodule

bind polar_unwarp_coordinate_generator pug_checker u_pug_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data),
    .i_psel      (psel),
    .i_penable   (penable),
    .i_pwrite    (pwrite),
    .i_paddr     (paddr),
    .i_pwdata    (pwdata),
    .i_prdata    (prdata),
    .i_pready    (pready)
);
